// ===== sv/ftmm_pkg.sv =====
// ----------------------------------------------------------------------------
// ftmm_pkg
// Shared types, constants and helpers for the frame timing metrics monitor.
// ----------------------------------------------------------------------------
package ftmm_pkg;

    localparam int TIME_W      = 48;
    localparam int SUM_W       = 64;
    localparam int CNT_W       = 32;
    localparam int TGT_W       = 20;
    localparam int TOL_W       = 16;
    localparam int CFG_W       = 20;
    localparam int CMD_W       = 3;
    localparam int SEL_W       = 4;
    localparam int DEN_W       = 32;
    localparam int HIST_DEPTH_DEF = 32;

    localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(16667);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1500);

    // register indexes
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_TOL    = 1'b1;

    // commands
    localparam logic [CMD_W-1:0] OP_FRAME = 3'd0;
    localparam logic [CMD_W-1:0] OP_DROP  = 3'd1;
    localparam logic [CMD_W-1:0] OP_SKIP  = 3'd2;
    localparam logic [CMD_W-1:0] OP_READ  = 3'd3;
    localparam logic [CMD_W-1:0] OP_CLEAR = 3'd4;

    // metric selectors
    localparam logic [SEL_W-1:0] MET_TOTAL   = 4'd0;
    localparam logic [SEL_W-1:0] MET_AVG     = 4'd1;
    localparam logic [SEL_W-1:0] MET_WORST   = 4'd2;
    localparam logic [SEL_W-1:0] MET_LAT     = 4'd3;
    localparam logic [SEL_W-1:0] MET_QUEUE   = 4'd4;
    localparam logic [SEL_W-1:0] MET_SCHED   = 4'd5;
    localparam logic [SEL_W-1:0] MET_SWAP    = 4'd6;
    localparam logic [SEL_W-1:0] MET_DROP    = 4'd7;
    localparam logic [SEL_W-1:0] MET_SKIP    = 4'd8;
    localparam logic [SEL_W-1:0] MET_LATE    = 4'd9;
    localparam logic [SEL_W-1:0] MET_EARLY   = 4'd10;
    localparam logic [SEL_W-1:0] MET_BURST   = 4'd11;
    localparam logic [SEL_W-1:0] MET_FDEV    = 4'd12;
    localparam logic [SEL_W-1:0] MET_PDEV    = 4'd13;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DIV_START, S_DIV_WAIT, S_DEV_CHK, S_WALK
    } t_state;

    typedef enum logic [2:0] {
        JOB_QUEUE, JOB_SCHED, JOB_SWAP, JOB_LAT, JOB_FRAME, JOB_FDEV, JOB_PDEV
    } t_job;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_store;
        t_job job;
        logic walk_start;
        logic walk_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_frame;
        logic fi_ok;
        logic dev_ok;
        logic walk_done;
        logic div_done;
        logic out_hold;
    } t_dp_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] diff_or_zero(input logic [TIME_W-1:0] hi,
                                                       input logic [TIME_W-1:0] lo);
        return (hi > lo) ? hi - lo : '0;
    endfunction

endpackage

// ===== sv/frame_timing_metrics_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// frame_timing_metrics_monitor_unit
// Frame timing statistics: delays, intervals, history deviation, event counts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall| cmd, entry, 5 stamps, select
//  out     | output    | o_out_valid/i_out_stall| metric_index, metric_value
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
//  Work per item: a non-frame item is executed and done. A valid frame-complete
//  item runs four divisions (a fifth when an interval is formed) on the shared
//  64-step divider, plus, when deviation is updated, a history walk over the
//  filled entries (one memory read per cycle) and two more divisions.
//  Reset: synchronous, active low; stats and history valid bits clear at once.
//  Stalls: a read result waits in the output register; a new item is held
//  off only while a result waits stalled or an item is still in work.
// ----------------------------------------------------------------------------
module frame_timing_metrics_monitor_unit #(
    parameter int HISTORY_DEPTH = ftmm_pkg::HIST_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ftmm_pkg::CFG_W-1:0]    i_cfg_data,
    // item in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ftmm_pkg::CMD_W-1:0]    i_cmd,
    input  logic                          i_entry_valid,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_submit_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_queue_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_schedule_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_present_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_completion_time,
    input  logic [ftmm_pkg::SEL_W-1:0]    i_metric_select,
    // result out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ftmm_pkg::SEL_W-1:0]    o_metric_index,
    output logic [ftmm_pkg::TIME_W-1:0]   o_metric_value
);
    import ftmm_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // sequencer
    ftmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // statistics, history and result register
    ftmm_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd_code        (i_cmd),
        .i_entry_valid     (i_entry_valid),
        .i_submit_time     (i_submit_time),
        .i_queue_time      (i_queue_time),
        .i_schedule_time   (i_schedule_time),
        .i_present_time    (i_present_time),
        .i_completion_time (i_completion_time),
        .i_metric_select   (i_metric_select),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_metric_index    (o_metric_index),
        .o_metric_value    (o_metric_value)
    );

endmodule

// ===== sv/ftmm_div.sv =====
// ----------------------------------------------------------------------------
// ftmm_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftmm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ftmm_pkg::SUM_W-1:0]   i_num,
    input  logic [ftmm_pkg::DEN_W-1:0]   i_den,
    output logic [ftmm_pkg::SUM_W-1:0]   o_quot,
    output logic                         o_done
);
    import ftmm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    trial;
    logic              qbit;

    always_comb begin
        trial = {r_rem, r_q[SUM_W-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= (i_den == '0) ? DEN_W'(1) : i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], qbit};
            r_rem <= qbit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ===== sv/ftmm_dp.sv =====
// ----------------------------------------------------------------------------
// ftmm_dp
// Datapath: statistics registers, interval history memories, output register.
// ----------------------------------------------------------------------------
module ftmm_dp #(
    parameter int HISTORY_DEPTH = ftmm_pkg::HIST_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ftmm_pkg::t_ctrl_cmd           i_cmd,
    output ftmm_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ftmm_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [ftmm_pkg::CMD_W-1:0]    i_cmd_code,
    input  logic                          i_entry_valid,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_submit_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_queue_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_schedule_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_present_time,
    input  logic [ftmm_pkg::TIME_W-1:0]   i_completion_time,
    input  logic [ftmm_pkg::SEL_W-1:0]    i_metric_select,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ftmm_pkg::SEL_W-1:0]    o_metric_index,
    output logic [ftmm_pkg::TIME_W-1:0]   o_metric_value
);
    import ftmm_pkg::*;

    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    // latched item
    logic [CMD_W-1:0]  r_op;
    logic              r_ev_ok;
    logic [TIME_W-1:0] r_sub, r_que, r_sch, r_pre, r_cmp;
    logic [SEL_W-1:0]  r_sel;

    // statistics
    logic [TGT_W-1:0]  r_tgt;
    logic [TOL_W-1:0]  r_tol;
    logic [CNT_W-1:0]  r_fc;
    logic [SUM_W-1:0]  r_sum [5];
    logic [TIME_W-1:0] r_tm [8];
    logic [CNT_W-1:0]  r_ev [5];
    logic [TIME_W-1:0] r_last_c, r_last_p;
    logic [HW-1:0]     r_head;
    logic [FW-1:0]     r_fill;
    logic              r_fi_ok;

    // history
    logic [TIME_W-1:0]        r_fring [HISTORY_DEPTH];
    logic [TIME_W-1:0]        r_pring [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_fvld, r_pvld;
    logic [TIME_W-1:0]        r_fd, r_pd;
    logic                     r_fdv, r_pdv;

    // walk
    logic [FW-1:0]     r_widx;
    logic              r_pend;
    logic [SUM_W-1:0]  r_sf, r_sp;

    logic              r_out_valid;
    logic [SEL_W-1:0]  r_out_idx;
    logic [TIME_W-1:0] r_out_val;

    // divider
    logic [SUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [SUM_W-1:0]  div_q;
    logic              div_done;
    logic [TIME_W-1:0] q_clamped;

    logic [TIME_W-1:0] fi, pi, d_q, d_s, d_w, d_l, fdat, pdat, fdist, pdist;
    logic              fi_ok, pi_ok, rd_en;
    logic [HW-1:0]     head_inc;
    logic [CNT_W-1:0]  fc_inc;
    logic [TIME_W-1:0] met_val;

    ftmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    always_comb begin
        fc_inc = sat_inc(r_fc);
        d_q    = diff_or_zero(r_que, r_sub);
        d_s    = diff_or_zero(r_pre, r_que);
        d_w    = diff_or_zero(r_cmp, r_pre);
        d_l    = diff_or_zero(r_cmp, r_sub);
        fi_ok  = (r_last_c != '0) && (r_cmp > r_last_c);
        pi_ok  = (r_last_p != '0) && (r_pre > r_last_p);
        fi     = r_cmp - r_last_c;
        pi     = r_pre - r_last_p;
        head_inc = (r_head == HW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
        q_clamped = (div_q[SUM_W-1:TIME_W] != '0) ? '1 : div_q[TIME_W-1:0];
        fdat  = r_fdv ? r_fd : '0;
        pdat  = r_pdv ? r_pd : '0;
        fdist = (fdat > r_tm[0]) ? fdat - r_tm[0] : r_tm[0] - fdat;
        pdist = (pdat > r_tm[0]) ? pdat - r_tm[0] : r_tm[0] - pdat;
        rd_en = i_cmd.walk_step && (r_widx < r_fill);
    end

    always_comb begin
        div_num = r_sum[0];
        div_den = r_fc;
        unique case (i_cmd.job)
            JOB_QUEUE: div_num = r_sum[0];
            JOB_SCHED: div_num = r_sum[1];
            JOB_SWAP:  div_num = r_sum[2];
            JOB_LAT:   div_num = r_sum[3];
            JOB_FRAME: begin
                div_num = r_sum[4];
                div_den = r_fc - 1'b1;
            end
            JOB_FDEV: begin
                div_num = r_sf;
                div_den = DEN_W'(r_fill);
            end
            JOB_PDEV: begin
                div_num = r_sp;
                div_den = DEN_W'(r_fill);
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_sel)
            MET_TOTAL: met_val = TIME_W'(r_fc);
            MET_AVG:   met_val = r_tm[0];
            MET_WORST: met_val = r_tm[1];
            MET_LAT:   met_val = r_tm[2];
            MET_QUEUE: met_val = r_tm[3];
            MET_SCHED: met_val = r_tm[4];
            MET_SWAP:  met_val = r_tm[5];
            MET_DROP:  met_val = TIME_W'(r_ev[0]);
            MET_SKIP:  met_val = TIME_W'(r_ev[1]);
            MET_LATE:  met_val = TIME_W'(r_ev[2]);
            MET_EARLY: met_val = TIME_W'(r_ev[3]);
            MET_BURST: met_val = TIME_W'(r_ev[4]);
            MET_FDEV:  met_val = r_tm[6];
            MET_PDEV:  met_val = r_tm[7];
            default:   met_val = '0;
        endcase
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_cmd_code;
            r_ev_ok <= i_entry_valid;
            r_sub   <= i_submit_time;
            r_que   <= i_queue_time;
            r_sch   <= i_schedule_time;
            r_pre   <= i_present_time;
            r_cmp   <= i_completion_time;
            r_sel   <= i_metric_select;
        end
    end

    // history memories: one write, one read port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_op == OP_FRAME && r_ev_ok && fi_ok)
            r_fring[r_head] <= fi;
        if (rd_en)
            r_fd <= r_fring[r_widx[HW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_op == OP_FRAME && r_ev_ok && pi_ok)
            r_pring[r_head] <= pi;
        if (rd_en)
            r_pd <= r_pring[r_widx[HW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
            r_pvld <= '0;
        end else if (i_cmd.exec && r_op == OP_FRAME && r_ev_ok) begin
            if (fi_ok) r_fvld[r_head] <= 1'b1;
            if (pi_ok) r_pvld[r_head] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_fdv <= r_fvld[r_widx[HW-1:0]];
            r_pdv <= r_pvld[r_widx[HW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt      <= TGT_RESET;
            r_tol      <= TOL_RESET;
            r_fc       <= '0;
            r_sum      <= '{default: '0};
            r_tm       <= '{default: '0};
            r_ev       <= '{default: '0};
            r_last_c   <= '0;
            r_last_p   <= '0;
            r_head     <= '0;
            r_fill     <= '0;
            r_fi_ok    <= 1'b0;
            r_widx     <= '0;
            r_pend     <= 1'b0;
            r_sf       <= '0;
            r_sp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TARGET: r_tgt <= i_cfg_data[TGT_W-1:0];
                    REG_TOL:    r_tol <= i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;

            if (i_cmd.exec) begin
                unique case (r_op)
                    OP_FRAME: begin
                        if (r_ev_ok) begin
                            r_fc     <= fc_inc;
                            r_sum[0] <= sat_add(r_sum[0], d_q);
                            r_sum[1] <= sat_add(r_sum[1], d_s);
                            r_sum[2] <= sat_add(r_sum[2], d_w);
                            r_sum[3] <= sat_add(r_sum[3], d_l);
                            r_fi_ok  <= fi_ok;
                            if (fi_ok) begin
                                r_sum[4] <= sat_add(r_sum[4], fi);
                                if (fi > r_tm[1])
                                    r_tm[1] <= fi;
                                if (r_tgt != '0 && fi < TIME_W'(r_tgt >> 1))
                                    r_ev[4] <= sat_inc(r_ev[4]);
                            end
                            r_last_c <= r_cmp;
                            r_last_p <= r_pre;
                            r_head   <= head_inc;
                            if (r_fill < FW'(HISTORY_DEPTH))
                                r_fill <= r_fill + 1'b1;
                            if (r_sch != '0 && r_pre != '0) begin
                                if (r_pre > r_sch && (r_pre - r_sch) > TIME_W'(r_tol))
                                    r_ev[2] <= sat_inc(r_ev[2]);
                                else if (r_sch > r_pre &&
                                         (r_sch - r_pre) > TIME_W'(r_tol))
                                    r_ev[3] <= sat_inc(r_ev[3]);
                            end
                        end
                    end
                    OP_DROP: r_ev[0] <= sat_inc(r_ev[0]);
                    OP_SKIP: r_ev[1] <= sat_inc(r_ev[1]);
                    OP_READ: begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_sel;
                        r_out_val   <= met_val;
                    end
                    OP_CLEAR: begin
                        r_fc     <= '0;
                        r_sum    <= '{default: '0};
                        r_tm     <= '{default: '0};
                        r_ev     <= '{default: '0};
                        r_last_c <= '0;
                        r_last_p <= '0;
                        r_head   <= '0;
                        r_fill   <= '0;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.div_store) begin
                unique case (i_cmd.job)
                    JOB_QUEUE: r_tm[3] <= q_clamped;
                    JOB_SCHED: r_tm[4] <= q_clamped;
                    JOB_SWAP:  r_tm[5] <= q_clamped;
                    JOB_LAT:   r_tm[2] <= q_clamped;
                    JOB_FRAME: r_tm[0] <= q_clamped;
                    JOB_FDEV:  r_tm[6] <= q_clamped;
                    JOB_PDEV:  r_tm[7] <= q_clamped;
                    default: ;
                endcase
            end

            if (i_cmd.walk_start) begin
                r_widx <= '0;
                r_pend <= 1'b0;
                r_sf   <= '0;
                r_sp   <= '0;
            end else if (i_cmd.walk_step) begin
                r_pend <= rd_en;
                if (rd_en)
                    r_widx <= r_widx + 1'b1;
                if (r_pend) begin
                    r_sf <= sat_add(r_sf, fdist);
                    r_sp <= sat_add(r_sp, pdist);
                end
            end
        end
    end

    always_comb begin
        o_stat.is_frame  = (r_op == OP_FRAME) && r_ev_ok;
        o_stat.fi_ok     = r_fi_ok;
        o_stat.dev_ok    = (r_fill > FW'(1)) && (r_tm[0] != '0);
        o_stat.walk_done = (r_widx == r_fill) && !r_pend && !i_cmd.walk_start;
        o_stat.div_done  = div_done;
        o_stat.out_hold  = r_out_valid && i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_metric_index = r_out_idx;
    assign o_metric_value = r_out_val;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH))
        else $error("history fill above depth");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.exec) && $past(r_op) == OP_READ)
        else $error("result without a read command");

    a_store_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_store |-> div_done)
        else $error("quotient stored before divider finished");

endmodule

// ===== sv/ftmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftmm_ctrl
// Controller: sequences item execution, divisions and the history walk.
// ----------------------------------------------------------------------------
module ftmm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ftmm_pkg::t_dp_stat    i_stat,
    output ftmm_pkg::t_ctrl_cmd   o_cmd
);
    import ftmm_pkg::*;

    t_state r_state, n_state;
    t_job   r_job, n_job;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE) || i_stat.out_hold;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_QUEUE;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: begin
                n_job   = JOB_QUEUE;
                n_state = i_stat.is_frame ? S_DIV_START : S_IDLE;
            end
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    unique case (r_job)
                        JOB_QUEUE: begin n_job = JOB_SCHED; n_state = S_DIV_START; end
                        JOB_SCHED: begin n_job = JOB_SWAP;  n_state = S_DIV_START; end
                        JOB_SWAP:  begin n_job = JOB_LAT;   n_state = S_DIV_START; end
                        JOB_LAT: begin
                            if (i_stat.fi_ok) begin
                                n_job   = JOB_FRAME;
                                n_state = S_DIV_START;
                            end else begin
                                n_state = S_DEV_CHK;
                            end
                        end
                        JOB_FRAME: n_state = S_DEV_CHK;
                        JOB_FDEV:  begin n_job = JOB_PDEV; n_state = S_DIV_START; end
                        JOB_PDEV:  n_state = S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DEV_CHK: n_state = i_stat.dev_ok ? S_WALK : S_IDLE;
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_job   = JOB_FDEV;
                    n_state = S_DIV_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.job        = r_job;
        o_cmd.load       = accept;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.div_start  = (r_state == S_DIV_START);
        o_cmd.div_store  = (r_state == S_DIV_WAIT) && i_stat.div_done;
        o_cmd.walk_start = (r_state == S_DEV_CHK);
        o_cmd.walk_step  = (r_state == S_WALK);
    end

endmodule
